// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/arlrf_pkg.sv =====
// ----------------------------------------------------------------------------
// arlrf_pkg
// Types and constants of the ARAP local rotation fit pipeline.
// ----------------------------------------------------------------------------
package arlrf_pkg;

    localparam int FRAC_BITS_DEF        = 16;
    localparam int ANGLE_ITERATIONS_DEF = 24;

    // CORDIC gain inverse and unity, Q1.30
    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
    localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] third_x;
        logic signed [31:0] third_y;
        logic signed [31:0] inv00;
        logic signed [31:0] inv01;
        logic signed [31:0] inv10;
        logic signed [31:0] inv11;
        logic        [31:0] area;
    } req_t;

    typedef struct packed {
        logic signed [31:0] rot00;
        logic signed [31:0] rot01;
        logic signed [31:0] rot10;
        logic signed [31:0] rot11;
        logic signed [31:0] target00;
        logic signed [31:0] target01;
        logic signed [31:0] target10;
        logic signed [31:0] target11;
        logic        [62:0] energy_term;
    } rsp_t;

endpackage

// ===== hw/rtl/arap_local_rotation_fit.sv =====
// ----------------------------------------------------------------------------
// arap_local_rotation_fit
// Per-triangle Jacobian, closest 2D rotation, target and energy term.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while no response stalls; the CORDIC and square
// root run one micro-step per pipeline stage side by side, energy products are split.
// A stalled response freezes the whole pipeline; nothing is dropped.
// Reset (rst_n, async, active low) clears all valid bits; data is not reset.
module arap_local_rotation_fit #(
    parameter int FRAC_BITS        = arlrf_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_ITERATIONS = arlrf_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  arlrf_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output arlrf_pkg::rsp_t  rsp
);

    localparam int F   = FRAC_BITS;
    localparam int AI  = ANGLE_ITERATIONS;
    localparam int PRW = 65;
    localparam int JW  = 66 - F;
    localparam int PW  = JW + 1;
    localparam int XW  = PW + 2;
    localparam int UW  = 33;
    localparam int VW  = 32 + F;
    localparam int SQ  = (VW + 1) / 2;
    localparam int RW  = 2 * SQ + 1;
    localparam int NS  = (AI > SQ) ? AI : SQ;
    localparam int DW  = 67 - F;
    localparam int LO  = (DW + 1) / 2;
    localparam int HI  = DW - LO;
    localparam int QW  = 2 * DW;
    localparam int SW  = QW + 2;
    localparam int CW  = (SW + 3) / 4;
    localparam int SWP = 4 * CW;
    localparam int MW  = SWP + 32;
    localparam int EW  = MW + 32;
    localparam int TW  = SQ + 33;

    localparam logic signed [32:0] RF_HALF = 33'sd1 <<< (29 - F);
    localparam logic signed [TW:0] T_HALF  = (TW + 1)'(1) <<< 29;

    logic en;
    assign en        = !rsp_valid || rsp_ready;
    assign req_ready = en;

    // ---------------- P1: edge differences
    logic               v1_reg;
    logic signed [32:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [31:0] i00_reg, i01_reg, i10_reg, i11_reg;
    logic        [31:0] a1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg  <= 33'(req.second_x) - 33'(req.first_x);
            ay_reg  <= 33'(req.second_y) - 33'(req.first_y);
            bx_reg  <= 33'(req.third_x) - 33'(req.first_x);
            by_reg  <= 33'(req.third_y) - 33'(req.first_y);
            i00_reg <= req.inv00;
            i01_reg <= req.inv01;
            i10_reg <= req.inv10;
            i11_reg <= req.inv11;
            a1_reg  <= req.area;
        end
    end

    // ---------------- P2: Jacobian products
    logic                v2_reg;
    logic signed [PRW-1:0] m_reg [8];
    logic        [31:0]  a2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= PRW'(ax_reg) * PRW'(i00_reg);
            m_reg[1] <= PRW'(bx_reg) * PRW'(i10_reg);
            m_reg[2] <= PRW'(ax_reg) * PRW'(i01_reg);
            m_reg[3] <= PRW'(bx_reg) * PRW'(i11_reg);
            m_reg[4] <= PRW'(ay_reg) * PRW'(i00_reg);
            m_reg[5] <= PRW'(by_reg) * PRW'(i10_reg);
            m_reg[6] <= PRW'(ay_reg) * PRW'(i01_reg);
            m_reg[7] <= PRW'(by_reg) * PRW'(i11_reg);
            a2_reg   <= a1_reg;
        end
    end

    // ---------------- P3: J entries, each product floored
    logic               v3_reg;
    logic signed [JW-1:0] j3_reg [4];
    logic        [31:0] a3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                j3_reg[k] <= JW'($signed(m_reg[2*k][PRW-1:F]))
                           + JW'($signed(m_reg[2*k+1][PRW-1:F]));
            end
            a3_reg <= a2_reg;
        end
    end

    // ---------------- P4: rotation vector
    logic               v4_reg;
    logic signed [PW-1:0] p_reg, q_reg;
    logic signed [JW-1:0] j4_reg [4];
    logic        [31:0] a4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= PW'(j3_reg[0]) + PW'(j3_reg[3]);
            q_reg  <= PW'(j3_reg[2]) - PW'(j3_reg[1]);
            j4_reg <= j3_reg;
            a4_reg <= a3_reg;
        end
    end

    // ---------------- P5 and CORDIC / square root stages
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [UW-1:0] ux;
        logic signed [UW-1:0] uy;
        logic        [RW-1:0] rem;
        logic        [RW-1:0] res;
        logic signed [JW-1:0] j0;
        logic signed [JW-1:0] j1;
        logic signed [JW-1:0] j2;
        logic signed [JW-1:0] j3;
        logic        [31:0]   area;
        logic                 zero;
    } cst_t;

    cst_t       cst_reg [NS+1];
    logic [NS:0] cv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= '0;
        end
        else if (en)
        begin
            cv_reg <= {cv_reg[NS-1:0], v4_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // left half-plane: turn by 180 degrees first
            cst_reg[0].x    <= p_reg[PW-1] ? -XW'(p_reg) : XW'(p_reg);
            cst_reg[0].y    <= p_reg[PW-1] ? -XW'(q_reg) : XW'(q_reg);
            cst_reg[0].ux   <= p_reg[PW-1] ? -arlrf_pkg::CORDIC_K : arlrf_pkg::CORDIC_K;
            cst_reg[0].uy   <= '0;
            cst_reg[0].rem  <= RW'({a4_reg, {F{1'b0}}});
            cst_reg[0].res  <= '0;
            cst_reg[0].j0   <= j4_reg[0];
            cst_reg[0].j1   <= j4_reg[1];
            cst_reg[0].j2   <= j4_reg[2];
            cst_reg[0].j3   <= j4_reg[3];
            cst_reg[0].area <= a4_reg;
            cst_reg[0].zero <= (p_reg == '0) && (q_reg == '0);
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_iter
        cst_t cur, nxt;
        assign cur = cst_reg[g];

        always_comb
        begin
            nxt = cur;
            if (g < AI)
            begin
                if (!cur.y[XW-1])
                begin
                    nxt.x  = cur.x + (cur.y >>> g);
                    nxt.y  = cur.y - (cur.x >>> g);
                    nxt.ux = cur.ux - (cur.uy >>> g);
                    nxt.uy = cur.uy + (cur.ux >>> g);
                end
                else
                begin
                    nxt.x  = cur.x - (cur.y >>> g);
                    nxt.y  = cur.y + (cur.x >>> g);
                    nxt.ux = cur.ux + (cur.uy >>> g);
                    nxt.uy = cur.uy - (cur.ux >>> g);
                end
            end
            if (g < SQ)
            begin
                // one restoring square-root digit
                if (cur.rem >= cur.res + (RW'(1) << (2 * (SQ - 1 - g))))
                begin
                    nxt.rem = cur.rem - cur.res - (RW'(1) << (2 * (SQ - 1 - g)));
                    nxt.res = (cur.res >> 1) + (RW'(1) << (2 * (SQ - 1 - g)));
                end
                else
                begin
                    nxt.res = cur.res >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cst_reg[g+1] <= nxt;
            end
        end
    end

    // ---------------- R1: clamp, identity for a zero vector
    localparam logic signed [UW-1:0] UMAX = UW'(arlrf_pkg::ONE_Q30);
    localparam logic signed [UW-1:0] UMIN = -UW'(arlrf_pkg::ONE_Q30);

    cst_t               last;
    logic               r1v_reg;
    logic signed [31:0] c1_reg, s1_reg;
    logic signed [JW-1:0] j_r1_reg [4];
    logic        [SQ-1:0] sa1_reg;
    logic        [31:0] a_r1_reg;

    assign last = cst_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1v_reg <= 1'b0;
        end
        else if (en)
        begin
            r1v_reg <= cv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (last.zero)
            begin
                c1_reg <= arlrf_pkg::ONE_Q30;
                s1_reg <= '0;
            end
            else
            begin
                c1_reg <= (last.ux > UMAX) ? 32'(UMAX) :
                          (last.ux < UMIN) ? 32'(UMIN) : 32'(last.ux);
                s1_reg <= (last.uy > UMAX) ? 32'(UMAX) :
                          (last.uy < UMIN) ? 32'(UMIN) : 32'(last.uy);
            end
            j_r1_reg[0] <= last.j0;
            j_r1_reg[1] <= last.j1;
            j_r1_reg[2] <= last.j2;
            j_r1_reg[3] <= last.j3;
            sa1_reg     <= last.res[SQ-1:0];
            a_r1_reg    <= last.area;
        end
    end

    // ---------------- R2: residual magnitudes, target products
    logic signed [32:0] rot_w [4];
    logic signed [32:0] rf_w  [4];
    logic signed [DW-1:0] df_w [4];

    always_comb
    begin
        rot_w[0] = 33'(c1_reg);
        rot_w[1] = -33'(s1_reg);
        rot_w[2] = 33'(s1_reg);
        rot_w[3] = 33'(c1_reg);
        for (int k = 0; k < 4; k++)
        begin
            rf_w[k] = (rot_w[k] + RF_HALF) >>> (30 - F);
            df_w[k] = DW'(j_r1_reg[k]) - DW'(rf_w[k]);
        end
    end

    logic               r2v_reg;
    logic        [DW-1:0] d2_reg [4];
    logic signed [TW-1:0] tc2_reg, ts2_reg;
    logic signed [31:0] c2_reg, s2_reg;
    logic        [31:0] a2r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2v_reg <= 1'b0;
        end
        else if (en)
        begin
            r2v_reg <= r1v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                d2_reg[k] <= df_w[k][DW-1] ? DW'(-df_w[k]) : DW'(df_w[k]);
            end
            tc2_reg <= TW'($signed({1'b0, sa1_reg})) * TW'(c1_reg);
            ts2_reg <= TW'($signed({1'b0, sa1_reg})) * TW'(s1_reg);
            c2_reg  <= c1_reg;
            s2_reg  <= s1_reg;
            a2r_reg <= a_r1_reg;
        end
    end

    // ---------------- R3: round/saturate targets, square partials
    function automatic logic signed [31:0] round_sat(input logic signed [TW:0] v);
        logic signed [TW:0] t;
        t = (v + T_HALF) >>> 30;
        if (t > (TW + 1)'(32'sh7FFFFFFF))
        begin
            return 32'sh7FFFFFFF;
        end
        else if (t < -(TW + 1)'(33'sh80000000))
        begin
            return 32'sh80000000;
        end
        return 32'(t);
    endfunction

    logic               r3v_reg;
    logic [2*LO-1:0]    ll3_reg [4];
    logic [2*HI-1:0]    hh3_reg [4];
    logic [LO+HI-1:0]   hl3_reg [4];
    logic signed [31:0] t3_reg [4];
    logic signed [31:0] c3_reg, s3_reg;
    logic        [31:0] a3r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r3v_reg <= 1'b0;
        end
        else if (en)
        begin
            r3v_reg <= r2v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ll3_reg[k] <= (2*LO)'(d2_reg[k][LO-1:0]) * (2*LO)'(d2_reg[k][LO-1:0]);
                hh3_reg[k] <= (2*HI)'(d2_reg[k][DW-1:LO]) * (2*HI)'(d2_reg[k][DW-1:LO]);
                hl3_reg[k] <= (LO+HI)'(d2_reg[k][DW-1:LO]) * (LO+HI)'(d2_reg[k][LO-1:0]);
            end
            t3_reg[0] <= round_sat((TW + 1)'(tc2_reg));
            t3_reg[1] <= round_sat(-(TW + 1)'(ts2_reg));
            t3_reg[2] <= round_sat((TW + 1)'(ts2_reg));
            t3_reg[3] <= round_sat((TW + 1)'(tc2_reg));
            c3_reg    <= c2_reg;
            s3_reg    <= s2_reg;
            a3r_reg   <= a2r_reg;
        end
    end

    // ---------------- R4..R6: squares and their sum
    logic            r4v_reg, r5v_reg, r6v_reg;
    logic [QW-1:0]   sq4_reg [4];
    logic [QW:0]     ps5_reg [2];
    logic [SW-1:0]   s6_reg;
    logic signed [31:0] t4_reg [4], t5_reg [4], t6_reg [4];
    logic signed [31:0] c4_reg, s4_reg, c5_reg, s5_reg, c6_reg, s6r_reg;
    logic [31:0]     a4r_reg, a5r_reg, a6r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r4v_reg <= 1'b0;
            r5v_reg <= 1'b0;
            r6v_reg <= 1'b0;
        end
        else if (en)
        begin
            r4v_reg <= r3v_reg;
            r5v_reg <= r4v_reg;
            r6v_reg <= r5v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sq4_reg[k] <= (QW'(hh3_reg[k]) << (2 * LO))
                            + (QW'(hl3_reg[k]) << (LO + 1))
                            + QW'(ll3_reg[k]);
            end
            ps5_reg[0] <= (QW + 1)'(sq4_reg[0]) + (QW + 1)'(sq4_reg[1]);
            ps5_reg[1] <= (QW + 1)'(sq4_reg[2]) + (QW + 1)'(sq4_reg[3]);
            s6_reg     <= SW'(ps5_reg[0]) + SW'(ps5_reg[1]);
            t4_reg  <= t3_reg;
            t5_reg  <= t4_reg;
            t6_reg  <= t5_reg;
            c4_reg  <= c3_reg;
            s4_reg  <= s3_reg;
            c5_reg  <= c4_reg;
            s5_reg  <= s4_reg;
            c6_reg  <= c5_reg;
            s6r_reg <= s5_reg;
            a4r_reg <= a3r_reg;
            a5r_reg <= a4r_reg;
            a6r_reg <= a5r_reg;
        end
    end

    // ---------------- R7, R8: times area, in four slices
    logic [SWP-1:0]  s_pad;
    assign s_pad = SWP'(s6_reg);

    logic            r7v_reg, r8v_reg;
    logic [CW+31:0]  pp7_reg [4];
    logic [MW-1:0]   full8_reg;
    logic signed [31:0] t7_reg [4], t8_reg [4];
    logic signed [31:0] c7_reg, s7_reg, c8_reg, s8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r7v_reg <= 1'b0;
            r8v_reg <= 1'b0;
        end
        else if (en)
        begin
            r7v_reg <= r6v_reg;
            r8v_reg <= r7v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pp7_reg[k] <= (CW + 32)'(s_pad[k*CW +: CW]) * (CW + 32)'(a6r_reg);
            end
            full8_reg <= MW'(pp7_reg[0])
                       + (MW'(pp7_reg[1]) << CW)
                       + (MW'(pp7_reg[2]) << (2 * CW))
                       + (MW'(pp7_reg[3]) << (3 * CW));
            t7_reg <= t6_reg;
            t8_reg <= t7_reg;
            c7_reg <= c6_reg;
            s7_reg <= s6r_reg;
            c8_reg <= c7_reg;
            s8_reg <= s7_reg;
        end
    end

    // ---------------- R9: scale to Q31.32, saturate, output register
    logic [EW-1:0] ext_w;
    assign ext_w = {full8_reg, 32'd0} >> (3 * F);

    logic           ov_reg;
    arlrf_pkg::rsp_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= r8v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg.rot00    <= c8_reg;
            rsp_reg.rot01    <= -s8_reg;
            rsp_reg.rot10    <= s8_reg;
            rsp_reg.rot11    <= c8_reg;
            rsp_reg.target00 <= t8_reg[0];
            rsp_reg.target01 <= t8_reg[1];
            rsp_reg.target10 <= t8_reg[2];
            rsp_reg.target11 <= t8_reg[3];
            rsp_reg.energy_term <= (|ext_w[EW-1:63]) ? '1 : ext_w[62:0];
        end
    end

    assign rsp_valid = ov_reg;
    assign rsp       = rsp_reg;

    // ---------------- checks
`include "assert_macros.svh"

    `ASSERT_IMPL(a_cos_pair, clk, rst_n, rsp_valid, rsp.rot00 == rsp.rot11, "cos entries differ")
    `ASSERT_IMPL(a_sin_pair, clk, rst_n, rsp_valid, rsp.rot01 == -rsp.rot10, "sin entries not opposed")
    `ASSERT_IMPL(a_cos_range, clk, rst_n, rsp_valid, (rsp.rot00 <= arlrf_pkg::ONE_Q30) && (rsp.rot00 >= -arlrf_pkg::ONE_Q30), "cos out of range")
    `ASSERT_NEXT(a_stall_freeze, clk, rst_n, rsp_valid && !rsp_ready, r8v_reg == $past(r8v_reg), "pipeline moved under stall")

endmodule

// ===== test/arap_local_rotation_fit_tb.sv =====
// ----------------------------------------------------------------------------
// arap_local_rotation_fit_tb
// Streams triangles through the rotation fit pipeline and checks every
// response against an in-bench fixed point predictor. Both handshake sides
// idle at random, with one long response hold-off to back up the pipeline.
// ----------------------------------------------------------------------------
module arap_local_rotation_fit_tb;

    localparam int  FB         = 16;
    localparam int  ITERS      = 24;
    localparam int  IDLE_LIMIT = 5000;
    localparam int  N_RANDOM   = 630;
    localparam longint K_GAIN  = 652032874;
    localparam longint UNITY   = 1073741824;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    arlrf_pkg::req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    arlrf_pkg::rsp_t  rsp;

    arlrf_pkg::req_t  pending_tris[$];
    arlrf_pkg::rsp_t  fit_expected[$];
    int    err_count;
    int    sent_count;
    int    rsp_count;
    int    idle_cycles;
    int    req_gap;
    int    rsp_wait;
    int    hold_left;
    bit    hold_done;
    bit    req_taken;
    bit    rsp_taken;

    arap_local_rotation_fit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint floor_shr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic arlrf_pkg::rsp_t fit_triangle(arlrf_pkg::req_t r);
        longint ax, ay, bx, by, p, q, x, y, ux, uy, dx, dy, dux, duy, c, s, sa, t, rf, df;
        longint jac[4];
        longint rot[4];
        logic [191:0] acc;
        logic [191:0] scaled;
        logic [63:0] d;
        arlrf_pkg::rsp_t o;
        ax = longint'(r.second_x) - longint'(r.first_x);
        ay = longint'(r.second_y) - longint'(r.first_y);
        bx = longint'(r.third_x) - longint'(r.first_x);
        by = longint'(r.third_y) - longint'(r.first_y);
        jac[0] = floor_shr(ax * longint'(r.inv00), FB) + floor_shr(bx * longint'(r.inv10), FB);
        jac[1] = floor_shr(ax * longint'(r.inv01), FB) + floor_shr(bx * longint'(r.inv11), FB);
        jac[2] = floor_shr(ay * longint'(r.inv00), FB) + floor_shr(by * longint'(r.inv10), FB);
        jac[3] = floor_shr(ay * longint'(r.inv01), FB) + floor_shr(by * longint'(r.inv11), FB);
        p = jac[0] + jac[3];
        q = jac[2] - jac[1];
        if (p == 0 && q == 0)
        begin
            c = UNITY;
            s = 0;
        end
        else
        begin
            x = p;
            y = q;
            ux = K_GAIN;
            uy = 0;
            // left half plane: turn by 180 degrees first
            if (x < 0)
            begin
                x = -x;
                y = -y;
                ux = -ux;
            end
            for (int i = 0; i < ITERS; i++)
            begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                dux = floor_shr(uy, i);
                duy = floor_shr(ux, i);
                if (y >= 0)
                begin
                    x = x + dx; y = y - dy; ux = ux - dux; uy = uy + duy;
                end
                else
                begin
                    x = x - dx; y = y + dy; ux = ux + dux; uy = uy - duy;
                end
            end
            c = sat(ux, -UNITY, UNITY);
            s = sat(uy, -UNITY, UNITY);
        end
        rot[0] = c;
        rot[1] = -s;
        rot[2] = s;
        rot[3] = c;
        sa = longint'(int_sqrt({32'd0, r.area} << FB));
        acc = '0;
        o.rot00 = rot[0][31:0];
        o.rot01 = rot[1][31:0];
        o.rot10 = rot[2][31:0];
        o.rot11 = rot[3][31:0];
        for (int k = 0; k < 4; k++)
        begin
            t = sat(floor_shr(sa * rot[k] + (64'sd1 <<< 29), 30),
                    -64'sd2147483648, 64'sd2147483647);
            rf = floor_shr(rot[k] + (64'sd1 <<< (29 - FB)), 30 - FB);
            df = jac[k] - rf;
            d = (df < 0) ? -df : df;
            acc = acc + {128'd0, d} * {128'd0, d};
            case (k)
                0: o.target00 = t[31:0];
                1: o.target01 = t[31:0];
                2: o.target10 = t[31:0];
                default: o.target11 = t[31:0];
            endcase
        end
        acc = acc * {160'd0, r.area};
        scaled = acc >> (3 * FB - 32);
        o.energy_term = (|scaled[191:63]) ? {63{1'b1}} : scaled[62:0];
        return o;
    endfunction

    function automatic arlrf_pkg::req_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                               int i00, int i01, int i10, int i11,
                                               int unsigned ar);
        arlrf_pkg::req_t r;
        r.first_x = ax;  r.first_y = ay;
        r.second_x = bx; r.second_y = by;
        r.third_x = cx;  r.third_y = cy;
        r.inv00 = i00;   r.inv01 = i01;
        r.inv10 = i10;   r.inv11 = i11;
        r.area = ar;
        return r;
    endfunction

    function automatic int small_val(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic arlrf_pkg::req_t rand_tri();
        arlrf_pkg::req_t r;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
        begin
            // raw bit noise
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        else
        begin
            r = mk_tri(small_val(1 << 20), small_val(1 << 20), small_val(1 << 20),
                       small_val(1 << 20), small_val(1 << 20), small_val(1 << 20),
                       small_val(1 << 18), small_val(1 << 18), small_val(1 << 18),
                       small_val(1 << 18), $urandom_range(0, 1 << 22));
            if (sel == 2)
                r.area = $urandom;
        end
        return r;
    endfunction

    // acceptance flags for the falling edge processes, plus prediction
    always @(posedge clk)
    begin
        req_taken <= req_valid && req_ready;
        rsp_taken <= rsp_valid && rsp_ready;
        if (rst_n && req_valid && req_ready)
            fit_expected.push_back(fit_triangle(req));
    end

    // request driver
    always @(negedge clk)
    begin
        bit   vld;
        arlrf_pkg::req_t nxt;
        vld = req_valid;
        nxt = req;
        if (rst_n)
        begin
            if (vld && req_taken)
            begin
                vld = 1'b0;
                req_gap = ((sent_count / 100) % 3 == 2) ? 0 : $urandom_range(0, 9);
            end
            if (!vld)
            begin
                if (req_gap > 0)
                    req_gap = req_gap - 1;
                else if (pending_tris.size() > 0)
                begin
                    nxt = pending_tris.pop_front();
                    vld = 1'b1;
                    sent_count = sent_count + 1;
                end
            end
        end
        req_valid <= vld;
        req <= nxt;
    end

    // response side stalls, with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
                rsp_wait = ((rsp_count / 100) % 3 == 1) ? 0 : $urandom_range(0, 9);
            if (!hold_done && rsp_count >= 250)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (rsp_wait > 0)
            begin
                rsp_wait = rsp_wait - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // response checker
    always @(posedge clk)
    begin
        arlrf_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_count <= rsp_count + 1;
            if (fit_expected.size() == 0)
            begin
                err_count = err_count + 1;
                if (err_count <= 10)
                    $display("unexpected response %h", rsp);
            end
            else
            begin
                want = fit_expected.pop_front();
                if (rsp.rot00 !== want.rot00 || rsp.rot01 !== want.rot01 ||
                    rsp.rot10 !== want.rot10 || rsp.rot11 !== want.rot11 ||
                    rsp.target00 !== want.target00 || rsp.target01 !== want.target01 ||
                    rsp.target10 !== want.target10 || rsp.target11 !== want.target11 ||
                    rsp.energy_term !== want.energy_term)
                begin
                    err_count = err_count + 1;
                    if (err_count <= 10)
                    begin
                        $display("mismatch rot exp %h %h %h %h got %h %h %h %h",
                                 want.rot00, want.rot01, want.rot10, want.rot11,
                                 rsp.rot00, rsp.rot01, rsp.rot10, rsp.rot11);
                        $display("  target exp %h %h %h %h got %h %h %h %h",
                                 want.target00, want.target01, want.target10,
                                 want.target11, rsp.target00, rsp.target01,
                                 rsp.target10, rsp.target11);
                        $display("  energy exp %h got %h", want.energy_term,
                                 rsp.energy_term);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int one;
        int mx;
        int mn;
        one = 1 << FB;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        rst_n = 1'b0;
        req_valid = 1'b0;
        rsp_ready = 1'b0;
        req = '0;
        err_count = 0;
        sent_count = 0;
        rsp_count = 0;
        idle_cycles = 0;
        req_gap = 0;
        rsp_wait = 0;
        hold_left = 0;
        hold_done = 1'b0;
        req_taken = 1'b0;
        rsp_taken = 1'b0;

        // identity, rotation, reflection, left half plane
        pending_tris.push_back(mk_tri(0, 0, one, 0, 0, one, one, 0, 0, one, one));
        pending_tris.push_back(mk_tri(0, 0, 0, one, -one, 0, one, 0, 0, one, 4 * one));
        pending_tris.push_back(mk_tri(0, 0, one, 0, 0, -one, one, 0, 0, one, one));
        pending_tris.push_back(mk_tri(0, 0, -one, 0, 0, -one, one, 0, 0, one, one));
        pending_tris.push_back(mk_tri(5, 7, -3 * one, one, one, 2 * one, one, one, 0, one, 3));
        // zero rotation vector, and one with only p zero
        pending_tris.push_back(mk_tri(0, 0, 0, 0, 0, 0, one, 0, 0, one, one));
        pending_tris.push_back(mk_tri(0, 0, one, 0, 0, one, 0, one, -one, 0, one));
        pending_tris.push_back(mk_tri(0, 0, one, 0, 0, one, one, 0, 0, -one, one));
        // zero area
        pending_tris.push_back(mk_tri(0, 0, 3 * one, one, one, 2 * one, one, 0, 0, one, 0));
        // extremes and saturating energy
        pending_tris.push_back(mk_tri(mn, mn, mx, mx, mx, mn, mx, mx, mx, mx, 32'hffffffff));
        pending_tris.push_back(mk_tri(mx, mx, mn, mn, mn, mx, mn, mn, mn, mn, 32'hffffffff));
        pending_tris.push_back(mk_tri(mx, mn, mn, mx, mx, mx, mx, mn, mn, mx, 32'hffffffff));
        pending_tris.push_back(mk_tri(mn, mx, mx, mn, mn, mn, mn, mx, mx, mn, 0));
        pending_tris.push_back(mk_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 32'hffffffff));
        pending_tris.push_back(mk_tri(0, 0, mx, 0, 0, mx, mx, 0, 0, mx, 32'hffffffff));
        pending_tris.push_back(mk_tri(0, 0, 1, 0, 0, 1, 1, 0, 0, 1, 1));
        for (int i = 0; i < N_RANDOM; i++)
            pending_tris.push_back(rand_tri());

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_tris.size() == 0 && !req_valid);
        wait (fit_expected.size() == 0);
        repeat (60) @(posedge clk);
        if (fit_expected.size() != 0)
            err_count = err_count + 1;
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/arlrf_pkg.sv
hw/rtl/arap_local_rotation_fit.sv
test/arap_local_rotation_fit_tb.sv
